// ===== src/baq_pkg.sv =====
// shared constants, types and functions of the block-average four-level quantizer
// no dependencies; used by baq_scan and the top level by scoped names
package baq_pkg;

    // block columns kept in the accumulator memory
    localparam int MAX_COLUMNS = 400;

    // image dimensions
    localparam int DIM_W        = 14;
    localparam int POS_W        = 13;
    localparam int DIM_LIMIT    = 8192;
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    // block side, ceil(width / MAX_COLUMNS)
    localparam int MAX_SIDE   = (DIM_LIMIT + MAX_COLUMNS - 1) / MAX_COLUMNS;
    localparam int RESET_SIDE = (RESET_WIDTH + MAX_COLUMNS - 1) / MAX_COLUMNS;
    localparam int SIDE_W     = $clog2(MAX_SIDE + 1);

    // reciprocal of MAX_COLUMNS, exact for the whole range of width + MAX_COLUMNS - 1
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + MAX_COLUMNS - 1) / MAX_COLUMNS;

    // block column index and counter
    localparam int BC_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int BCNT_W = $clog2(MAX_COLUMNS + 1);

    // accumulator entry: pixel sum and pixel count of one block
    localparam int CNT_W = $clog2(MAX_SIDE * MAX_SIDE + 1);
    localparam int SUM_W = $clog2(MAX_SIDE * MAX_SIDE * 255 + 1);
    localparam int ACC_W = SUM_W + CNT_W;
    localparam int CMP_W = SUM_W + CNT_W + 2;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = CFG_IDX_W'(1);

    typedef struct packed {
        logic [BC_W-1:0] addr;
        logic            fresh;
        logic            emit;
        logic            row_start;
        logic            img_end;
    } scan_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        r = d;
        if (d == '0)
            r = DIM_W'(1);
        else if (d > DIM_W'(DIM_LIMIT))
            r = DIM_W'(DIM_LIMIT);
        return r;
    endfunction

    // level = number of k in 1..3 with 4*sum >= k*255*count
    function automatic logic [1:0] quantize(input logic [SUM_W-1:0] sum,
                                            input logic [CNT_W-1:0] count);
        logic [CMP_W-1:0] s4;
        logic [CMP_W-1:0] c1;
        logic [CMP_W-1:0] c2;
        logic [CMP_W-1:0] c3;
        logic [1:0]       lv;
        s4 = CMP_W'(sum) << 2;
        c1 = CMP_W'(count) * CMP_W'(255);
        c2 = CMP_W'(count) * CMP_W'(510);
        c3 = CMP_W'(count) * CMP_W'(765);
        if (s4 >= c3)
            lv = 2'd3;
        else if (s4 >= c2)
            lv = 2'd2;
        else if (s4 >= c1)
            lv = 2'd1;
        else
            lv = 2'd0;
        return lv;
    endfunction

endpackage

// ===== src/baq_ram.sv =====
// generic single-write, single-read RAM with registered read data
// no dependencies
module baq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // a read at the address being written returns the old word
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/baq_scan.sv =====
// raster position counters, image size registers and block side
// depends on baq_pkg
module baq_scan (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [baq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [baq_pkg::DIM_W-1:0]      cfg_data,
    input  logic                           step,
    output baq_pkg::scan_t                 scan
);

    logic [baq_pkg::POS_W-1:0]  width_m1_reg,  width_m1_next;
    logic [baq_pkg::POS_W-1:0]  height_m1_reg, height_m1_next;
    logic [baq_pkg::SIDE_W-1:0] side_m1_reg,   side_m1_next;
    logic [baq_pkg::POS_W-1:0]  pixel_col_reg, pixel_col_next;
    logic [baq_pkg::POS_W-1:0]  pixel_row_reg, pixel_row_next;
    logic [baq_pkg::SIDE_W-1:0] col_in_block_reg, col_in_block_next;
    logic [baq_pkg::SIDE_W-1:0] row_in_band_reg,  row_in_band_next;
    logic [baq_pkg::BCNT_W-1:0] block_column_reg, block_column_next;

    logic [baq_pkg::DIM_W-1:0]                      dim;
    logic [baq_pkg::DIM_W:0]                        side_num;
    logic [baq_pkg::DIM_W+baq_pkg::RECIP_W:0]       side_prod;
    logic [baq_pkg::SIDE_W-1:0]                     side_val;
    logic                                           row_end;
    logic                                           block_end;
    logic                                           bottom_row;
    logic                                           last_row;
    logic                                           img_end;

    // ceil(width / MAX_COLUMNS) by reciprocal multiply
    always_comb
    begin
        dim       = baq_pkg::clamp_dim(cfg_data);
        side_num  = {1'b0, dim} + (baq_pkg::DIM_W+1)'(baq_pkg::MAX_COLUMNS - 1);
        side_prod = (baq_pkg::DIM_W+baq_pkg::RECIP_W+1)'(side_num)
                  * (baq_pkg::DIM_W+baq_pkg::RECIP_W+1)'(baq_pkg::RECIP);
        side_val  = baq_pkg::SIDE_W'(side_prod >> baq_pkg::RECIP_SHIFT);
    end

    always_comb
    begin
        row_end    = pixel_col_reg >= width_m1_reg;
        block_end  = col_in_block_reg >= side_m1_reg;
        bottom_row = pixel_row_reg >= height_m1_reg;
        last_row   = (row_in_band_reg >= side_m1_reg) || bottom_row;
        img_end    = row_end && bottom_row;

        if (block_column_reg >= baq_pkg::BCNT_W'(baq_pkg::MAX_COLUMNS))
            scan.addr = baq_pkg::BC_W'(baq_pkg::MAX_COLUMNS - 1);
        else
            scan.addr = block_column_reg[baq_pkg::BC_W-1:0];
        // first pixel of a block in its band starts a new accumulation
        scan.fresh     = (row_in_band_reg == '0) && (col_in_block_reg == '0);
        scan.emit      = (block_end || row_end) && last_row;
        scan.row_start = block_column_reg == '0;
        scan.img_end   = img_end;
    end

    always_comb
    begin
        width_m1_next     = width_m1_reg;
        height_m1_next    = height_m1_reg;
        side_m1_next      = side_m1_reg;
        pixel_col_next    = pixel_col_reg;
        pixel_row_next    = pixel_row_reg;
        col_in_block_next = col_in_block_reg;
        row_in_band_next  = row_in_band_reg;
        block_column_next = block_column_reg;

        if (cfg_write && (cfg_index == baq_pkg::CFG_WIDTH || cfg_index == baq_pkg::CFG_HEIGHT))
        begin
            if (cfg_index == baq_pkg::CFG_WIDTH)
            begin
                width_m1_next = baq_pkg::POS_W'(dim - baq_pkg::DIM_W'(1));
                side_m1_next  = side_val - baq_pkg::SIDE_W'(1);
            end
            else
            begin
                height_m1_next = baq_pkg::POS_W'(dim - baq_pkg::DIM_W'(1));
            end
            // a write to the width or height register restarts the frame
            pixel_col_next    = '0;
            pixel_row_next    = '0;
            col_in_block_next = '0;
            row_in_band_next  = '0;
            block_column_next = '0;
        end
        else if (step)
        begin
            if (row_end)
            begin
                pixel_col_next    = '0;
                col_in_block_next = '0;
                block_column_next = '0;
                if (img_end)
                begin
                    pixel_row_next   = '0;
                    row_in_band_next = '0;
                end
                else
                begin
                    pixel_row_next   = pixel_row_reg + baq_pkg::POS_W'(1);
                    row_in_band_next = last_row ? '0
                                     : row_in_band_reg + baq_pkg::SIDE_W'(1);
                end
            end
            else
            begin
                pixel_col_next = pixel_col_reg + baq_pkg::POS_W'(1);
                if (block_end)
                begin
                    col_in_block_next = '0;
                    block_column_next = block_column_reg + baq_pkg::BCNT_W'(1);
                end
                else
                begin
                    col_in_block_next = col_in_block_reg + baq_pkg::SIDE_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_m1_reg     <= baq_pkg::POS_W'(baq_pkg::RESET_WIDTH - 1);
            height_m1_reg    <= baq_pkg::POS_W'(baq_pkg::RESET_HEIGHT - 1);
            side_m1_reg      <= baq_pkg::SIDE_W'(baq_pkg::RESET_SIDE - 1);
            pixel_col_reg    <= '0;
            pixel_row_reg    <= '0;
            col_in_block_reg <= '0;
            row_in_band_reg  <= '0;
            block_column_reg <= '0;
        end
        else
        begin
            width_m1_reg     <= width_m1_next;
            height_m1_reg    <= height_m1_next;
            side_m1_reg      <= side_m1_next;
            pixel_col_reg    <= pixel_col_next;
            pixel_row_reg    <= pixel_row_next;
            col_in_block_reg <= col_in_block_next;
            row_in_band_reg  <= row_in_band_next;
            block_column_reg <= block_column_next;
        end
    end

endmodule

// ===== src/block_average_four_level_quantizer.sv =====
// top level: box downsample of a raster pixel stream with four-level block quantization
// depends on baq_pkg, baq_scan and baq_ram
//
//   channel   direction  handshake              payload
//   pixel in  input      in_valid / in_stall    pixel[7:0]
//   block out output     out_valid / out_stall  level[1:0], row_start, image_end
//   config    input      cfg_valid / cfg_ready  cfg_index[1:0], cfg_data[13:0]
//
// one pixel is taken every cycle while in_stall is low; the per-column accumulator
// memory is read at the transfer and written back when the pixel leaves the s1 stage,
// with a bypass for back to back pixels of the same block column. a block result
// passes from the s1 registers into the output register, where it waits while
// out_stall holds it. after reset the size is 640 x 480; accumulators need no
// clearing pass since each block starts from zero at its first pixel in the band. in_stall
// rises only when a finished block cannot move into a full, stalled output register.
module block_average_four_level_quantizer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    pixel,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    level,
    output logic                          row_start,
    output logic                          image_end,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [baq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [baq_pkg::DIM_W-1:0]     cfg_data
);

    baq_pkg::scan_t scan;

    logic in_xfer;
    logic out_free;
    logic s1_adv;

    logic                      s1_valid_reg;
    logic [7:0]                s1_pixel_reg;
    logic [baq_pkg::BC_W-1:0]  s1_addr_reg;
    logic                      s1_fresh_reg;
    logic                      s1_emit_reg;
    logic                      s1_row_start_reg;
    logic                      s1_end_reg;
    logic                      fwd_hit_reg;
    logic [baq_pkg::ACC_W-1:0] fwd_data_reg;

    logic                      out_valid_reg;
    logic [1:0]                level_reg;
    logic                      row_start_reg;
    logic                      image_end_reg;

    logic [baq_pkg::ACC_W-1:0] ram_rdata;
    logic [baq_pkg::ACC_W-1:0] acc_old;
    logic [baq_pkg::SUM_W-1:0] sum_new;
    logic [baq_pkg::CNT_W-1:0] cnt_new;
    logic [baq_pkg::ACC_W-1:0] acc_new;

    assign cfg_ready = 1'b1;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && (!s1_emit_reg || out_free);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_xfer  = in_valid && !in_stall;

    baq_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (in_xfer),
        .scan      (scan)
    );

    baq_ram #(
        .WIDTH (baq_pkg::ACC_W),
        .DEPTH (baq_pkg::MAX_COLUMNS)
    ) u_acc_ram (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_addr_reg),
        .wdata (acc_new),
        .re    (in_xfer),
        .raddr (scan.addr),
        .rdata (ram_rdata)
    );

    // entry layout: sum in the upper bits, count in the lower bits
    always_comb
    begin
        if (s1_fresh_reg)
            acc_old = '0;
        else if (fwd_hit_reg)
            acc_old = fwd_data_reg;
        else
            acc_old = ram_rdata;
        sum_new = acc_old[baq_pkg::ACC_W-1:baq_pkg::CNT_W] + baq_pkg::SUM_W'(s1_pixel_reg);
        cnt_new = acc_old[baq_pkg::CNT_W-1:0] + baq_pkg::CNT_W'(1);
        acc_new = {sum_new, cnt_new};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                s1_valid_reg <= 1'b1;
                // the write-back lands at this edge, too late for this read
                fwd_hit_reg  <= s1_adv && (s1_addr_reg == scan.addr);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv && s1_emit_reg)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_pixel_reg     <= pixel;
            s1_addr_reg      <= scan.addr;
            s1_fresh_reg     <= scan.fresh;
            s1_emit_reg      <= scan.emit;
            s1_row_start_reg <= scan.row_start;
            s1_end_reg       <= scan.img_end;
            fwd_data_reg     <= acc_new;
        end
        if (s1_adv && s1_emit_reg)
        begin
            level_reg     <= baq_pkg::quantize(sum_new, cnt_new);
            row_start_reg <= s1_row_start_reg;
            image_end_reg <= s1_end_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign level     = level_reg;
    assign row_start = row_start_reg;
    assign image_end = image_end_reg;

endmodule

// ===== verif/tb_block_average_four_level_quantizer.sv =====
// testbench for block_average_four_level_quantizer: a directed table, then random frames of
// many sizes; each block result is checked against a table entry or an in-bench model of the
// block averaging; depends on baq_pkg and the block's rtl; needs nothing else

module tb_block_average_four_level_quantizer;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIM_W         = baq_pkg::DIM_W;
    localparam int NCOL          = baq_pkg::MAX_COLUMNS;
    localparam int TARGET_PIXELS = 1850;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 20;
    localparam int QUIET_LIMIT   = 2000;

    // indexes past the register list, which the block must ignore
    localparam logic [baq_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = 2'd2;
    localparam logic [baq_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = 2'd3;

    typedef struct packed {
        logic [1:0] level;
        logic       row_start;
        logic       image_end;
    } block_res_t;

    typedef enum logic {ROW_PIXEL, ROW_WRITE} row_op_e;

    typedef struct {
        row_op_e                       op;
        logic [baq_pkg::CFG_IDX_W-1:0] idx;
        logic [DIM_W-1:0]              data;
        logic [7:0]                    pix;
        bit                            typed;
        bit                            has_res;
        block_res_t                    res;
    } stim_row_t;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    logic [7:0]                    pixel     = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [1:0]                    level;
    logic                          row_start;
    logic                          image_end;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [baq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]              cfg_data  = '0;

    // model of the block: sizes, per-column accumulators and raster position
    logic [DIM_W-1:0] img_w;
    logic [DIM_W-1:0] img_h;
    logic [16:0]      sum_mem [NCOL];
    logic [8:0]       cnt_mem [NCOL];
    logic [4:0]       side;
    logic [12:0]      pix_row;
    logic [12:0]      pix_col;
    logic [4:0]       band_row;
    logic [4:0]       blk_pos;
    logic [8:0]       blk_col;

    block_res_t pending_blocks[$];

    int mismatches   = 0;
    int pixels_sent  = 0;
    int blocks_seen  = 0;
    int writes_done  = 0;
    int quiet_cycles = 0;

    block_average_four_level_quantizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel     (pixel),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .level     (level),
        .row_start (row_start),
        .image_end (image_end),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic restart_frame();
        for (int i = 0; i < NCOL; i++)
        begin
            sum_mem[i] = '0;
            cnt_mem[i] = '0;
        end
        side     = 5'((int'(img_w) + NCOL - 1) / NCOL);
        pix_row  = '0;
        pix_col  = '0;
        band_row = '0;
        blk_pos  = '0;
        blk_col  = '0;
    endtask

    task automatic apply_register(input logic [baq_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] dim;
        dim = d;
        if (d == '0)
            dim = DIM_W'(1);
        else if (d > DIM_W'(baq_pkg::DIM_LIMIT))
            dim = DIM_W'(baq_pkg::DIM_LIMIT);
        if (idx == baq_pkg::CFG_WIDTH)
        begin
            img_w = dim;
            restart_frame();
        end
        else if (idx == baq_pkg::CFG_HEIGHT)
        begin
            img_h = dim;
            restart_frame();
        end
    endtask

    // add one pixel to its block column; a block closes at its last column and last row
    task automatic accumulate_pixel(input logic [7:0] p, output logic done,
                                    output block_res_t r);
        int          col;
        logic        row_end;
        logic        last_col;
        logic        last_row;
        logic        img_end;
        logic [19:0] s4;
        logic [19:0] c255;
        col          = (int'(blk_col) >= NCOL) ? NCOL - 1 : int'(blk_col);
        sum_mem[col] = sum_mem[col] + p;
        cnt_mem[col] = cnt_mem[col] + 1'b1;
        row_end  = (pix_col >= img_w - 1'b1);
        last_col = (blk_pos >= side - 1'b1) || row_end;
        last_row = (band_row >= side - 1'b1) || (pix_row >= img_h - 1'b1);
        img_end  = row_end && (pix_row >= img_h - 1'b1);
        done     = last_col && last_row;
        r        = '0;
        if (done)
        begin
            s4   = 20'(sum_mem[col]) << 2;
            c255 = 20'(cnt_mem[col]) * 20'd255;
            if (s4 >= 20'd3 * c255)
                r.level = 2'd3;
            else if (s4 >= 20'd2 * c255)
                r.level = 2'd2;
            else if (s4 >= c255)
                r.level = 2'd1;
            else
                r.level = 2'd0;
            r.row_start  = (col == 0);
            r.image_end  = img_end;
            sum_mem[col] = '0;
            cnt_mem[col] = '0;
        end
        if (row_end)
        begin
            pix_col = '0;
            blk_pos = '0;
            blk_col = '0;
            if (img_end)
            begin
                pix_row  = '0;
                band_row = '0;
            end
            else
            begin
                pix_row  = pix_row + 1'b1;
                band_row = last_row ? 5'd0 : band_row + 1'b1;
            end
        end
        else
        begin
            pix_col = pix_col + 1'b1;
            if (blk_pos >= side - 1'b1)
            begin
                blk_pos = '0;
                blk_col = blk_col + 1'b1;
            end
            else
                blk_pos = blk_pos + 1'b1;
        end
    endtask

    // lower valid and wait until every expected block has come out
    task automatic drain_outputs();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_blocks.size() != 0);
    endtask

    task automatic write_register(input logic [baq_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [DIM_W-1:0] d);
        drain_outputs();
        // a pixel that closes no block may still be in the pipeline
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_register(idx, d);
        writes_done++;
    endtask

    // typed rows carry their expected block; all others take the model's
    task automatic feed_pixel(input logic [7:0] p, input bit steady, input bit typed,
                              input bit want, input block_res_t exp_r);
        int         gap;
        logic       done;
        block_res_t r;
        gap = steady ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= p;
        do @(posedge clk); while (in_stall);
        pixels_sent++;
        accumulate_pixel(p, done, r);
        if (typed)
        begin
            if (want)
                pending_blocks = {pending_blocks, exp_r};
        end
        else if (done)
            pending_blocks = {pending_blocks, r};
    endtask

    function automatic stim_row_t write_row(input logic [baq_pkg::CFG_IDX_W-1:0] idx,
                                            input logic [DIM_W-1:0] d);
        stim_row_t row;
        row.op      = ROW_WRITE;
        row.idx     = idx;
        row.data    = d;
        row.pix     = '0;
        row.typed   = 1'b0;
        row.has_res = 1'b0;
        row.res     = '0;
        return row;
    endfunction

    function automatic stim_row_t pixel_row(input logic [7:0] p, input bit typed,
                                            input bit has_res, input block_res_t res);
        stim_row_t row;
        row.op      = ROW_PIXEL;
        row.idx     = '0;
        row.data    = '0;
        row.pix     = p;
        row.typed   = typed;
        row.has_res = has_res;
        row.res     = res;
        return row;
    endfunction

    // sink side: random stall before each transfer, with stretches of none
    initial
    begin : sink
        int hold;
        bit steady;
        steady = 1'b0;
        forever
        begin
            if ($urandom_range(0, 63) == 0)
                steady = !steady;
            hold = steady ? 0 : $urandom_range(0, 10);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin : monitor
        block_res_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                blocks_seen++;
                if (pending_blocks.size() == 0)
                begin
                    $error("unexpected block: level %0d row_start %0b image_end %0b",
                           level, row_start, image_end);
                    mismatches++;
                end
                else
                begin
                    want = pending_blocks.pop_front();
                    if (level !== want.level)
                    begin
                        $error("level: expected %0d, got %0d", want.level, level);
                        mismatches++;
                    end
                    if (row_start !== want.row_start)
                    begin
                        $error("row_start: expected %0b, got %0b", want.row_start, row_start);
                        mismatches++;
                    end
                    if (image_end !== want.image_end)
                    begin
                        $error("image_end: expected %0b, got %0b", want.image_end, image_end);
                        mismatches++;
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("timeout: no transfer for %0d cycles", quiet_cycles);
                    $display("simulation failed");
                    $finish;
                end
            end
        end
    end

    initial
    begin : stimulus
        stim_row_t        dir_tab[$];
        int               kind;
        int               ew;
        int               eh;
        int               n;
        int               cap;
        int               style;
        bit               steady;
        logic [7:0]       base;
        logic [7:0]       p;
        logic [DIM_W-1:0] wd;
        logic [DIM_W-1:0] hd;
        block_res_t       none;

        none  = '0;
        img_w = DIM_W'(baq_pkg::RESET_WIDTH);
        img_h = DIM_W'(baq_pkg::RESET_HEIGHT);
        restart_frame();

        // reset size 640 x 480 has 2 x 2 blocks: two pixels close nothing
        dir_tab = {dir_tab, pixel_row(8'd255, 1, 0, none)};
        dir_tab = {dir_tab, pixel_row(8'd0,   1, 0, none)};
        // zero sizes clamp to 1 x 1, so every pixel is a whole image
        dir_tab = {dir_tab, write_row(baq_pkg::CFG_WIDTH,  14'd0)};
        dir_tab = {dir_tab, write_row(baq_pkg::CFG_HEIGHT, 14'd0)};
        dir_tab = {dir_tab, pixel_row(8'd0,   1, 1, '{2'd0, 1'b1, 1'b1})};
        dir_tab = {dir_tab, pixel_row(8'd255, 1, 1, '{2'd3, 1'b1, 1'b1})};
        dir_tab = {dir_tab, pixel_row(8'd63,  1, 1, '{2'd0, 1'b1, 1'b1})};
        dir_tab = {dir_tab, pixel_row(8'd64,  1, 1, '{2'd1, 1'b1, 1'b1})};
        dir_tab = {dir_tab, pixel_row(8'd127, 1, 1, '{2'd1, 1'b1, 1'b1})};
        dir_tab = {dir_tab, pixel_row(8'd128, 1, 1, '{2'd2, 1'b1, 1'b1})};
        dir_tab = {dir_tab, pixel_row(8'd191, 1, 1, '{2'd2, 1'b1, 1'b1})};
        dir_tab = {dir_tab, pixel_row(8'd192, 1, 1, '{2'd3, 1'b1, 1'b1})};
        // writes past the register list leave the 1 x 1 frame alone
        dir_tab = {dir_tab, write_row(CFG_UNUSED_LO, 14'd5)};
        dir_tab = {dir_tab, write_row(CFG_UNUSED_HI, 14'h3fff)};
        dir_tab = {dir_tab, pixel_row(8'd200, 1, 1, '{2'd3, 1'b1, 1'b1})};
        // oversized values clamp to 8192, blocks 21 wide
        dir_tab = {dir_tab, write_row(baq_pkg::CFG_WIDTH,  14'h3fff)};
        dir_tab = {dir_tab, write_row(baq_pkg::CFG_HEIGHT, 14'd9000)};
        dir_tab = {dir_tab, pixel_row(8'd17,  0, 0, none)};
        dir_tab = {dir_tab, pixel_row(8'd240, 0, 0, none)};
        dir_tab = {dir_tab, pixel_row(8'd90,  0, 0, none)};
        // 3 x 2 image, then the wrap into the next image
        dir_tab = {dir_tab, write_row(baq_pkg::CFG_WIDTH,  14'd3)};
        dir_tab = {dir_tab, write_row(baq_pkg::CFG_HEIGHT, 14'd2)};
        dir_tab = {dir_tab, pixel_row(8'd10,  0, 0, none)};
        dir_tab = {dir_tab, pixel_row(8'd100, 0, 0, none)};
        dir_tab = {dir_tab, pixel_row(8'd170, 0, 0, none)};
        dir_tab = {dir_tab, pixel_row(8'd250, 0, 0, none)};
        dir_tab = {dir_tab, pixel_row(8'd65,  0, 0, none)};
        dir_tab = {dir_tab, pixel_row(8'd129, 0, 0, none)};
        dir_tab = {dir_tab, pixel_row(8'd33,  0, 0, none)};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].op == ROW_WRITE)
                write_register(dir_tab[i].idx, dir_tab[i].data);
            else
                feed_pixel(dir_tab[i].pix, 1'b0, dir_tab[i].typed, dir_tab[i].has_res,
                           dir_tab[i].res);
        end

        while (pixels_sent < TARGET_PIXELS)
        begin
            kind = $urandom_range(0, 19);
            cap  = 400;
            case (kind)
                0:
                begin
                    // widest rows: one row of 21-pixel blocks, never finished
                    ew  = 8192;
                    eh  = 1;
                    wd  = $urandom_range(0, 1) ? 14'd8192 : 14'($urandom_range(8193, 16383));
                    hd  = $urandom_range(0, 1) ? 14'd0 : 14'd1;
                    cap = 900;
                end
                1:
                begin
                    ew = 1;
                    eh = 8192;
                    wd = $urandom_range(0, 1) ? 14'd0 : 14'd1;
                    hd = 14'($urandom_range(8192, 16383));
                end
                2:
                begin
                    // 2 or 3 pixel blocks, partial at the right and bottom edges
                    ew  = $urandom_range(401, 820);
                    eh  = $urandom_range(1, 4);
                    wd  = 14'(ew);
                    hd  = 14'(eh);
                    cap = 900;
                end
                default:
                begin
                    ew = $urandom_range(1, 40);
                    eh = $urandom_range(1, 12);
                    wd = (ew == 1 && $urandom_range(0, 1) == 1) ? 14'd0 : 14'(ew);
                    hd = (eh == 1 && $urandom_range(0, 1) == 1) ? 14'd0 : 14'(eh);
                end
            endcase

            case ($urandom_range(0, 9))
                0:
                begin
                    // carry on with the frame in progress
                    ew = int'(img_w);
                    eh = int'(img_h);
                end
                1:
                begin
                    ew = int'(img_w);
                    write_register(baq_pkg::CFG_HEIGHT, hd);
                end
                default:
                begin
                    write_register(baq_pkg::CFG_WIDTH, wd);
                    write_register(baq_pkg::CFG_HEIGHT, hd);
                end
            endcase
            if ($urandom_range(0, 4) == 0)
                write_register($urandom_range(0, 1) ? CFG_UNUSED_LO : CFG_UNUSED_HI,
                               14'($urandom));

            n = ew * eh * $urandom_range(1, 2) + $urandom_range(0, ew);
            if (n > cap)
                n = $urandom_range(cap / 3, cap);
            if (n > TARGET_PIXELS - pixels_sent)
                n = TARGET_PIXELS - pixels_sent;
            style  = $urandom_range(0, 3);
            base   = $urandom_range(0, 1) ? 8'hff : 8'($urandom);
            steady = ($urandom_range(0, 3) == 0);

            repeat (n)
            begin
                case (style)
                    0: p = 8'($urandom);
                    // values around the level thresholds
                    1: p = 8'($urandom_range(0, 3) * 64 + $urandom_range(0, 2) - 1);
                    2: p = $urandom_range(0, 1) ? 8'hff : 8'h00;
                    default: p = base;
                endcase
                feed_pixel(p, steady, 1'b0, 1'b0, none);
                if ($urandom_range(0, 199) == 0)
                    drain_outputs();
            end
        end

        drain_outputs();
        repeat (END_CYCLES) @(posedge clk);
        $display("%0d pixels in, %0d blocks out, %0d register transfers", pixels_sent,
                 blocks_seen, writes_done);
        $display("frames from 1 x 1 up to 8192 wide or high, clamped and ignored writes,",
                 " stalls on both sides");
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
